FILE: design/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies; imported by spq_cell and sorted_priority_queue.
`default_nettype none

package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int KEY_W    = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [CNT_W-1:0]        count_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef struct packed {
        op_t  op;
        key_t key;
    } item_t;

    typedef struct packed {
        key_t   removed_key;
        logic   removed_valid;
        logic   rejected;
        key_t   front_key;
        count_t stored_count;
        logic   is_empty;
    } result_t;

    // Command broadcast to every cell in the row
    typedef struct packed {
        logic ins;
        logic rem;
        key_t key;
    } cell_cmd_t;

    // What a cell shows its neighbors
    typedef struct packed {
        logic valid;
        logic move;
        key_t key;
    } nbr_t;

endpackage

`default_nettype wire

FILE: design/spq_cell.sv
// One slot of the sorted row: holds a key and its valid bit.
// Depends on spq_pkg for the command and neighbor structs.
`default_nettype none

module spq_cell
    import spq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cell_cmd_t cmd,
    input  wire nbr_t      left,
    input  wire nbr_t      right,
    output nbr_t           self
);

    logic valid_reg;
    logic valid_next;
    key_t key_reg;
    key_t key_next;
    logic move;

    // Own key shifts right when the new key sorts strictly before it
    assign move = valid_reg && (cmd.key < key_reg);

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        if (cmd.ins)
        begin
            if (valid_reg && !move)
            begin
                // hold
            end
            else if (left.move)
            begin
                key_next   = left.key;
                valid_next = 1'b1;
            end
            else if (valid_reg || left.valid)
            begin
                key_next   = cmd.key;
                valid_next = 1'b1;
            end
        end
        else if (cmd.rem)
        begin
            // advance toward the front
            key_next   = right.key;
            valid_next = right.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign self.valid = valid_reg;
    assign self.move  = move;
    assign self.key   = key_reg;

endmodule

`default_nettype wire

FILE: design/sorted_priority_queue.sv
// Channel | Signals              | Handshake
// --------+----------------------+-----------------------------------------
// command | start, busy, item    | beat taken at clk when start && !busy
// result  | done, result         | one beat, done high for one cycle
//
// One command per cycle: the row of cells compares combinationally and shifts
// as the command is taken, and the result beat appears on the cycle after the command.
// busy stays low; the row never holds off a command.
// rst_n clears the count and every cell's valid bit; no clearing pass.
// The receiver cannot stall; a result beat is shown once and dropped.
// Depends on spq_pkg and spq_cell.
`default_nettype none

module sorted_priority_queue
    import spq_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    output logic       busy,
    input  wire item_t item,
    output logic       done,
    output result_t    result
);

    count_t    count_reg;
    count_t    count_next;
    logic      done_reg;
    result_t   result_reg;
    result_t   result_next;
    logic      accept;
    logic      full;
    logic      empty;
    logic      do_ins;
    logic      do_rem;
    cell_cmd_t cmd;
    nbr_t      cells [CAPACITY];
    nbr_t      left_tie;
    nbr_t      right_tie;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == CNT_W'(CAPACITY));
    assign empty  = (count_reg == '0);
    assign do_ins = accept && (item.op == OP_INSERT) && !full;
    assign do_rem = accept && (item.op == OP_REMOVE) && !empty;

    assign cmd.ins = do_ins;
    assign cmd.rem = do_rem;
    assign cmd.key = item.key;

    assign left_tie.valid  = 1'b1;
    assign left_tie.move   = 1'b0;
    assign left_tie.key    = '0;
    assign right_tie.valid = 1'b0;
    assign right_tie.move  = 1'b0;
    assign right_tie.key   = '0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        spq_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd),
            .left  ((i == 0) ? left_tie : cells[(i == 0) ? 0 : i - 1]),
            .right ((i == CAPACITY - 1) ? right_tie
                                        : cells[(i == CAPACITY - 1) ? i : i + 1]),
            .self  (cells[i])
        );
    end

    always_comb
    begin
        count_next  = count_reg;
        result_next = '0;
        if (do_ins)
        begin
            count_next = count_reg + CNT_W'(1);
            if (empty || (item.key < cells[0].key))
            begin
                result_next.front_key = item.key;
            end
            else
            begin
                result_next.front_key = cells[0].key;
            end
        end
        else if (do_rem)
        begin
            count_next                = count_reg - CNT_W'(1);
            result_next.removed_key   = cells[0].key;
            result_next.removed_valid = 1'b1;
            result_next.front_key     = (count_reg > CNT_W'(1)) ? cells[1].key : '0;
        end
        else
        begin
            // drop: full insert or empty remove
            result_next.rejected  = 1'b1;
            result_next.front_key = empty ? '0 : cells[0].key;
        end
        result_next.stored_count = count_next;
        result_next.is_empty     = (count_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            done_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("count exceeds capacity");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("result beat missing after command");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.is_empty == (result.stored_count == '0)))
        else $error("empty flag disagrees with count");

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.removed_valid && result.rejected))
        else $error("removed and rejected both set");

    a_front_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> cells[0].valid)
        else $error("front cell empty while count is nonzero");
`endif

endmodule

`default_nettype wire
